// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the bus master.
// Depends on nothing; take in with `include before the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/owbm_pkg.sv =====
// Shared types and constants of the single-wire bus master.
// Depends on nothing; imported by every module of the block.
package owbm_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int BYTE_BITS      = 8;
    localparam int BIT_IDX_BITS   = 3;
    localparam int CFG_COUNT      = 8;
    localparam int CFG_BITS       = 10;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int S_TDATA_BITS   = 16;
    localparam int S_TUSER_BITS   = 2;
    localparam int M_TDATA_BITS   = 16;

    typedef logic [CFG_BITS-1:0] cfg_word_t;
    typedef cfg_word_t [CFG_COUNT-1:0] cfg_bank_t;

    localparam logic [CFG_ADDR_BITS-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PRES_WAIT    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RESET_REC    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WRITE_LOW    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WRITE_HOLD   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_READ_LOW     = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_READ_REC     = 3'd7;

    localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
        10'd500, 10'd70, 10'd500, 10'd10, 10'd50, 10'd5, 10'd5, 10'd50
    };

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                 cmd_rejected;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 presence_level;
        logic                 done_res;
        logic                 busy_res;
        logic                 line_drive;
    } res_t;

endpackage

// ===== hw/rtl/owbm_cfg.sv =====
// Configuration register bank: eight pulse lengths in microseconds.
// Depends on owbm_pkg.
module owbm_cfg
    import owbm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  cfg_word_t                cfg_wdata,
    output cfg_bank_t                cfg_bank
);

    cfg_bank_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign cfg_bank = cfg_reg;

endmodule

// ===== hw/rtl/owbm_core.sv =====
// Bus sequencer: phase, slot timer, bit counter and shift data, one step per request.
// Depends on owbm_pkg; takes the register bank of owbm_cfg as an input.
module owbm_core
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_fire,
    input  logic [1:0]           req_type,
    input  logic [BYTE_BITS-1:0] tx_byte,
    input  logic                 line_level,
    input  cfg_bank_t            cfg_bank,
    output res_t                 res
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_REC   = 3'd3,
        PH_SLOT_LOW  = 3'd4,
        PH_SLOT_MID  = 3'd5,
        PH_SLOT_REST = 3'd6,
        PH_GAP       = 3'd7
    } phase_t;

    localparam logic [16:0]             TMAX     = 17'((1 << TIMER_BITS) - 1);
    localparam logic [BIT_IDX_BITS-1:0] BIT_LAST = BIT_IDX_BITS'(BYTE_BITS - 1);

    phase_t                  phase_reg,    phase_next;
    logic [TIMER_BITS-1:0]   timer_reg,    timer_next;
    logic [BIT_IDX_BITS-1:0] bit_idx_reg,  bit_idx_next;
    logic [BYTE_BITS-1:0]    shift_reg,    shift_next;
    cmd_t                    cmd_reg,      cmd_next;
    logic                    drive_reg,    drive_next;
    logic                    presence_reg, presence_next;
    logic [BYTE_BITS-1:0]    rx_reg,       rx_next;
    logic                    done;
    logic                    rejected;
    logic                    slot_end;
    req_t                    req;

    function automatic logic [TIMER_BITS-1:0] load_time(input cfg_word_t w);
        logic [16:0] t;
        t = 17'(w);
        if (t == 17'd0) t = 17'd1;
        if (t > TMAX) t = TMAX;
        return TIMER_BITS'(t);
    endfunction

    assign req = req_t'(req_type);

    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        cmd_next      = cmd_reg;
        drive_next    = drive_reg;
        presence_next = presence_reg;
        rx_next       = rx_reg;
        done          = 1'b0;
        rejected      = 1'b0;
        slot_end      = 1'b0;

        if (req == REQ_TICK) begin
            if (phase_reg != PH_IDLE && timer_reg > TIMER_BITS'(1)) begin
                timer_next = timer_reg - TIMER_BITS'(1);
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_RST_LOW: begin
                        drive_next = 1'b1;
                        phase_next = PH_RST_WAIT;
                        timer_next = load_time(cfg_bank[REG_PRES_WAIT]);
                    end
                    PH_RST_WAIT: begin
                        presence_next = line_level;
                        phase_next    = PH_RST_REC;
                        timer_next    = load_time(cfg_bank[REG_RESET_REC]);
                    end
                    PH_RST_REC: begin
                        phase_next = PH_IDLE;
                        cmd_next   = CMD_NONE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                    PH_SLOT_LOW: begin
                        phase_next = PH_SLOT_MID;
                        if (cmd_reg == CMD_WRITE) begin
                            drive_next = shift_reg[bit_idx_reg];
                            timer_next = load_time(cfg_bank[REG_WRITE_HOLD]);
                        end else begin
                            drive_next = 1'b1;
                            timer_next = load_time(cfg_bank[REG_READ_SAMPLE]);
                        end
                    end
                    PH_SLOT_MID: begin
                        if (cmd_reg == CMD_WRITE) begin
                            slot_end = 1'b1;
                        end else begin
                            if (line_level) shift_next[bit_idx_reg] = 1'b1;
                            phase_next = PH_SLOT_REST;
                            timer_next = load_time(cfg_bank[REG_READ_REC]);
                        end
                    end
                    PH_SLOT_REST: begin
                        slot_end = 1'b1;
                    end
                    PH_GAP: begin
                        drive_next = 1'b0;
                        phase_next = PH_SLOT_LOW;
                        timer_next = (cmd_reg == CMD_WRITE)
                                   ? load_time(cfg_bank[REG_WRITE_LOW])
                                   : load_time(cfg_bank[REG_READ_LOW]);
                    end
                    default: begin
                    end
                endcase

                if (slot_end) begin
                    drive_next = 1'b1;
                    if (bit_idx_reg == BIT_LAST) begin
                        if (cmd_reg == CMD_READ) rx_next = shift_reg;
                        phase_next   = PH_IDLE;
                        cmd_next     = CMD_NONE;
                        timer_next   = '0;
                        bit_idx_next = '0;
                        done         = 1'b1;
                    end else begin
                        bit_idx_next = bit_idx_reg + BIT_IDX_BITS'(1);
                        phase_next   = PH_GAP;
                        timer_next   = TIMER_BITS'(1);
                    end
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            rejected = 1'b1;
        end else begin
            cmd_next     = cmd_t'(req_type);
            bit_idx_next = '0;
            drive_next   = 1'b0;
            if (req == REQ_RESET) begin
                phase_next = PH_RST_LOW;
                timer_next = load_time(cfg_bank[REG_RESET_LOW]);
            end else begin
                shift_next = (req == REQ_WRITE) ? tx_byte : '0;
                phase_next = PH_SLOT_LOW;
                timer_next = (req == REQ_WRITE)
                           ? load_time(cfg_bank[REG_WRITE_LOW])
                           : load_time(cfg_bank[REG_READ_LOW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            cmd_reg      <= CMD_NONE;
            drive_reg    <= 1'b1;
            presence_reg <= 1'b1;
            rx_reg       <= '0;
        end else if (req_fire) begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            cmd_reg      <= cmd_next;
            drive_reg    <= drive_next;
            presence_reg <= presence_next;
            rx_reg       <= rx_next;
        end
    end

    always_comb begin
        res.line_drive     = drive_next;
        res.busy_res       = (phase_next != PH_IDLE);
        res.done_res       = done;
        res.presence_level = presence_next;
        res.rx_byte        = rx_next;
        res.cmd_rejected   = rejected;
    end

endmodule

// ===== hw/rtl/owbm_out.sv =====
// Result register with a skid stage, so a request is taken while a result waits.
// Depends on owbm_pkg.
module owbm_out
    import owbm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end else if (in_valid && !skid_valid_reg) begin
            skid_res_reg <= in_res;
        end
    end

endmodule

// ===== hw/rtl/onewire_bus_master.sv =====
// Channel   Dir  Ports              Contents
// request   in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: tx_byte, line_level
// result    out  m_tvalid/m_tready  m_tdata: drive, busy, done, presence, rx_byte, rejected
// config    in   cfg_we             cfg_addr selects one of eight 10-bit pulse lengths
//
// One request per cycle while s_tready is high; each request yields one registered result.
// The sequencer state advances in a single pass per request; the two-entry
// result buffer keeps s_tready high through a single stalled result.
// Synchronous active-low reset restores the default pulse lengths and idles the bus.
// Top level of the single-wire bus master; depends on owbm_pkg, owbm_cfg,
// owbm_core and owbm_out.
module onewire_bus_master
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [7:0] tx_byte, [8] line_level
    input  logic [S_TUSER_BITS-1:0]  s_tuser,   // [1:0] req_type
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata,   // [0] line_drive, [1] busy_res,
                                                // [2] done_res, [3] presence_level,
                                                // [11:4] rx_byte, [12] cmd_rejected
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]      cfg_wdata
);

    cfg_bank_t cfg_bank;
    res_t      core_res;
    res_t      out_res;
    logic      req_fire;

    assign req_fire = s_tvalid && s_tready;

    owbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg_bank  (cfg_bank)
    );

    owbm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_fire   (req_fire),
        .req_type   (s_tuser),
        .tx_byte    (s_tdata[BYTE_BITS-1:0]),
        .line_level (s_tdata[BYTE_BITS]),
        .cfg_bank   (cfg_bank),
        .res        (core_res)
    );

    owbm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (req_fire),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.cmd_rejected, out_res.rx_byte,
                      out_res.presence_level, out_res.done_res,
                      out_res.busy_res, out_res.line_drive};

endmodule

// ===== hw/rtl/owbm_checker.sv =====
// Port-level checker of the single-wire bus master, bound to the top level.
// Depends on owbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module owbm_port_checks
    import owbm_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [S_TDATA_BITS-1:0]  s_tdata,
    input logic [S_TUSER_BITS-1:0]  s_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_BITS-1:0]  m_tdata,
    input logic                     cfg_we,
    input logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input logic [CFG_BITS-1:0]      cfg_wdata
);

    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_done_idle, aclk, aresetn, m_tvalid && m_tdata[2], !m_tdata[1])
    `ASSERT_IMPL(a_reject_busy, aclk, aresetn, m_tvalid && m_tdata[12], m_tdata[1])
    `ASSERT_IMPL(a_idle_release, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[0])

endmodule

bind onewire_bus_master owbm_port_checks u_owbm_port_checks (.*);
